>>> rtl/core/orthotropic_plane_stress_update_assert.svh
// Assertion macros of the orthotropic plane-stress RTL, used by the controller.
`ifndef ORTHOTROPIC_PLANE_STRESS_UPDATE_ASSERT_SVH
`define ORTHOTROPIC_PLANE_STRESS_UPDATE_ASSERT_SVH

// The condition on the right must hold in the same cycle as the one on the left.
`define OPSU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("opsu assertion failed");

// The condition on the right must hold in the cycle after the one on the left.
`define OPSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("opsu assertion failed");

`endif

>>> rtl/core/opsu_pkg.sv
// Package: types, constants and helper functions of the plane-stress block.
package opsu_pkg;

  // Fixed-point layout
  localparam int STRAIN_FRAC_BITS = 30;
  localparam int FRAC_SHIFT       = 32;
  localparam int Y_SHIFT          = STRAIN_FRAC_BITS - 16;
  localparam int E_SHIFT          = STRAIN_FRAC_BITS + 1;
  localparam int MOD_SHIFT        = 28;
  localparam int NU_SHIFT         = 14;

  // Divider geometry
  localparam int DIV_STEPS     = 128;
  localparam int QUO_BITS      = 47;
  localparam int DIV_OVF_STEPS = DIV_STEPS - QUO_BITS;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MOD_ONE,
    REG_MOD_TWO,
    REG_POISSON,
    REG_SHEAR,
    REG_ROT_COS,
    REG_ROT_SIN
  } reg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_MUL,
    S_CHK_WAIT,
    S_CHK_DEC,
    S_D_MUL,
    S_D_WAIT,
    S_D_DIV,
    S_D_DWAIT,
    S_MAC_CLR,
    S_MAC_MUL,
    S_MAC_WAIT,
    S_MAC_END,
    S_OUT
  } state_t;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    MS_NNE2,
    MS_AA,
    MS_AB,
    MS_ABN,
    MS_DT,
    MS_TM,
    MS_GE,
    MS_EY
  } mul_sel_t;

  // Local stiffness term being divided out
  typedef enum logic [1:0] {
    DS_D00,
    DS_D11,
    DS_D01
  } dsel_t;

  // Multiply-accumulate phase
  typedef enum logic [1:0] {
    PH_M,
    PH_G,
    PH_Y,
    PH_E
  } phase_t;

  // Datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH_IN,
    ACT_CHECK,
    ACT_LOAD_NUM,
    ACT_STORE_D,
    ACT_CLR_ACC,
    ACT_ACC,
    ACT_STORE_M,
    ACT_STORE_G,
    ACT_ROW,
    ACT_ENERGY,
    ACT_OUT
  } act_t;

  // Controller to datapath
  typedef struct packed {
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     div_start;
    act_t     act;
    logic [1:0] i;
    logic [1:0] j;
    logic [1:0] q;
    dsel_t    dsel;
  } opsu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic div_busy;
    logic div_done;
    logic bad;
    logic opcode;
    logic out_full;
  } opsu_stat_t;

  typedef struct packed {
    logic [63:0] val;
    logic        clip;
  } sat_t;

  // Clip a 128-bit value to the signed 64-bit range.
  function automatic sat_t sat_s64(input logic [127:0] x);
    sat_t r;
    r.clip = !((&x[127:63]) || !(|x[127:63]));
    if (r.clip) begin
      r.val = x[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      r.val = x[63:0];
    end
    return r;
  endfunction

  // Clip a 128-bit value to the signed 48-bit range.
  function automatic logic [47:0] sat_s48(input logic [127:0] x);
    logic ok;
    ok = (&x[127:47]) || !(|x[127:47]);
    if (ok) begin
      return x[47:0];
    end
    return x[127] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
  endfunction

  // Flat index of entry (r, c) of a 3x3 matrix.
  function automatic logic [3:0] idx9(input logic [1:0] r, input logic [1:0] c);
    return {1'b0, r, 1'b0} + {2'b0, r} + {2'b0, c};
  endfunction

  // Entry of the Voigt stress transform, 32 fractional bits.
  function automatic logic signed [37:0] t_entry(input logic [3:0] k,
                                                 input logic signed [35:0] cc,
                                                 input logic signed [35:0] ss,
                                                 input logic signed [35:0] cs);
    logic signed [37:0] cc_x;
    logic signed [37:0] ss_x;
    logic signed [37:0] cs_x;
    cc_x = {{2{cc[35]}}, cc};
    ss_x = {{2{ss[35]}}, ss};
    cs_x = {{2{cs[35]}}, cs};
    case (k)
      4'd0:    return cc_x;
      4'd1:    return ss_x;
      4'd2:    return cs_x <<< 1;
      4'd3:    return ss_x;
      4'd4:    return cc_x;
      4'd5:    return -(cs_x <<< 1);
      4'd6:    return -cs_x;
      4'd7:    return cs_x;
      4'd8:    return cc_x - ss_x;
      default: return '0;
    endcase
  endfunction

endpackage

>>> rtl/core/opsu_if.sv
// Channel interfaces: strain input, result output and configuration write.
interface opsu_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] strain_x;
  logic signed [31:0] strain_y;
  logic signed [31:0] strain_shear;
  modport source (output valid, opcode, strain_x, strain_y, strain_shear, input ready);
  modport sink   (input valid, opcode, strain_x, strain_y, strain_shear, output ready);
endinterface

interface opsu_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] stress_x;
  logic signed [63:0] stress_y;
  logic signed [63:0] stress_shear;
  logic signed [63:0] energy;
  logic               saturated;
  logic               config_error;
  modport source (output valid, stress_x, stress_y, stress_shear, energy, saturated,
                  config_error, input ready);
  modport sink   (input valid, stress_x, stress_y, stress_shear, energy, saturated,
                  config_error, output ready);
endinterface

interface opsu_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/opsu_mul.sv
// Multi-cycle signed multiplier: one 32x32 partial product per cycle.
module opsu_mul (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic         a_neg,
  input  logic [63:0]  a_mag,
  input  logic         b_neg,
  input  logic [63:0]  b_mag,
  output logic         busy,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic         neg_r;
  logic [2:0]   cnt_r;
  logic         busy_r;
  logic         done_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [127:0] sum_r;
  logic [127:0] prod_r;
  logic [31:0]  a_half;
  logic [31:0]  b_half;

  // Pick the halves for this partial product
  always_comb begin
    a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
    b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];
  end

  // Control: busy from start until done is raised
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial products, shifted accumulation and final sign
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a_mag;
      b_r   <= b_mag;
      neg_r <= a_neg ^ b_neg;
      sum_r <= '0;
    end else if (busy_r) begin
      if (cnt_r < 3'd4) begin
        pp_r <= a_half * b_half;
        sh_r <= {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
      end
      if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
        sum_r <= sum_r + ({64'b0, pp_r} << {sh_r, 5'b0});
      end
      if (cnt_r == 3'd5) begin
        prod_r <= neg_r ? (~sum_r + 128'd1) : sum_r;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = prod_r;

endmodule

>>> rtl/core/opsu_div.sv
// Restoring divider: 128-bit numerator by 64-bit divisor, one bit a cycle.
module opsu_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic         busy,
  output logic         done,
  output logic [46:0]  quo
);

  logic [127:0] num_r;
  logic [63:0]  den_r;
  logic [63:0]  rem_r;
  logic [46:0]  q_r;
  logic         ovf_r;
  logic [6:0]   step_r;
  logic         busy_r;
  logic         done_r;
  logic [64:0]  rem_sh;
  logic         ge;
  logic [64:0]  rem_sub;

  // One trial subtraction
  always_comb begin
    rem_sh  = {rem_r, num_r[127]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 7'd1;
        if (step_r == 7'(opsu_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits above the kept width mark an overflow
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[126:0], 1'b0};
      rem_r <= ge ? rem_sub[63:0] : rem_sh[63:0];
      q_r   <= {q_r[45:0], ge};
      if (ge && step_r < 7'(opsu_pkg::DIV_OVF_STEPS)) begin
        ovf_r <= 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = ovf_r ? {47{1'b1}} : q_r;

endmodule

>>> rtl/core/opsu_datapath.sv
// Datapath: registers, stiffness store, shared multiplier and divider, result register.
module opsu_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  opsu_pkg::opsu_cmd_t    cmd,
  output opsu_pkg::opsu_stat_t   stat,
  input  logic                   cfg_wr,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   in_opcode,
  input  logic signed [31:0]     in_strain_x,
  input  logic signed [31:0]     in_strain_y,
  input  logic signed [31:0]     in_strain_shear,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [63:0]     out_stress_x,
  output logic signed [63:0]     out_stress_y,
  output logic signed [63:0]     out_stress_shear,
  output logic signed [63:0]     out_energy,
  output logic                   out_saturated,
  output logic                   out_config_error
);

  // Configuration registers
  logic [31:0]        e1_r;
  logic [31:0]        e2_r;
  logic signed [15:0] nu_r;
  logic [31:0]        g12_r;
  logic signed [17:0] cos_r;
  logic signed [17:0] sin_r;

  // Values derived from configuration
  logic [30:0]        nn_r;
  logic signed [31:0] nn_full;
  logic [15:0]        nmag;
  logic signed [35:0] cc_r;
  logic signed [35:0] ss_r;
  logic signed [35:0] cs_r;

  // Build state
  logic               bad_r;
  logic [63:0]        k_r;
  logic [63:0]        ab_r;
  logic [127:0]       num_r;
  logic signed [47:0] d00_r;
  logic signed [47:0] d01_r;
  logic signed [47:0] d11_r;
  logic signed [63:0] m_r [9];
  logic signed [47:0] dg_r [9];

  // Item state
  logic               op_r;
  logic signed [31:0] e_r [3];
  logic signed [127:0] acc_r;
  logic signed [63:0] stress_r [3];
  logic signed [63:0] ysat_r [3];
  logic signed [63:0] energy_r;
  logic               clip_r;

  // Result register
  logic               out_valid_r;
  logic signed [63:0] out_sx_r;
  logic signed [63:0] out_sy_r;
  logic signed [63:0] out_ss_r;
  logic signed [63:0] out_en_r;
  logic               out_sat_r;
  logic               out_bad_r;

  // Shared units
  logic               mul_busy;
  logic               mul_done;
  logic [127:0]       mul_prod;
  logic               div_busy;
  logic               div_done;
  logic [46:0]        div_quo;

  logic signed [64:0] opa;
  logic signed [64:0] opb;
  logic [64:0]        opa_abs;
  logic [64:0]        opb_abs;
  logic [3:0]         k_iq;
  logic [3:0]         k_jq;
  logic [3:0]         k_qj;
  logic [3:0]         k_ij;
  logic signed [47:0] d_iq;
  logic signed [37:0] t_iq;
  logic signed [37:0] t_jq;
  logic signed [127:0] y_row;
  logic signed [127:0] row_sum;
  opsu_pkg::sat_t     row_sat;
  opsu_pkg::sat_t     y_sat;
  opsu_pkg::sat_t     m_sat;
  opsu_pkg::sat_t     en_sat;
  logic               cfg_bad;
  logic [46:0]        quo_x;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_r  <= 32'd65536;
      e2_r  <= 32'd65536;
      nu_r  <= '0;
      g12_r <= 32'd65536;
      cos_r <= 18'sd65536;
      sin_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        opsu_pkg::REG_MOD_ONE: e1_r  <= cfg_data;
        opsu_pkg::REG_MOD_TWO: e2_r  <= cfg_data;
        opsu_pkg::REG_POISSON: nu_r  <= cfg_data[15:0];
        opsu_pkg::REG_SHEAR:   g12_r <= cfg_data;
        opsu_pkg::REG_ROT_COS: cos_r <= cfg_data[17:0];
        opsu_pkg::REG_ROT_SIN: sin_r <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Squares and products of the configuration, refreshed every cycle
  always_comb begin
    nn_full = nu_r * nu_r;
    nmag    = nu_r[15] ? (~nu_r + 16'd1) : nu_r;
  end

  always_ff @(posedge clk) begin
    nn_r <= nn_full[30:0];
    cc_r <= cos_r * cos_r;
    ss_r <= sin_r * sin_r;
    cs_r <= cos_r * sin_r;
  end

  // Matrix entries addressed by the controller's indexes
  always_comb begin
    k_iq = opsu_pkg::idx9(cmd.i, cmd.q);
    k_jq = opsu_pkg::idx9(cmd.j, cmd.q);
    k_qj = opsu_pkg::idx9(cmd.q, cmd.j);
    k_ij = opsu_pkg::idx9(cmd.i, cmd.j);
    t_iq = opsu_pkg::t_entry(k_iq, cc_r, ss_r, cs_r);
    t_jq = opsu_pkg::t_entry(k_jq, cc_r, ss_r, cs_r);
    case (k_iq)
      4'd0:    d_iq = d00_r;
      4'd1:    d_iq = d01_r;
      4'd3:    d_iq = d01_r;
      4'd4:    d_iq = d11_r;
      4'd8:    d_iq = {16'b0, g12_r};
      default: d_iq = '0;
    endcase
  end

  // Multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      opsu_pkg::MS_NNE2: begin
        opa = {34'b0, nn_r};
        opb = {33'b0, e2_r};
      end
      opsu_pkg::MS_AA: begin
        opa = {33'b0, e1_r};
        opb = {33'b0, e1_r};
      end
      opsu_pkg::MS_AB: begin
        opa = {33'b0, e1_r};
        opb = {33'b0, e2_r};
      end
      opsu_pkg::MS_ABN: begin
        opa = {1'b0, ab_r};
        opb = {49'b0, nmag};
      end
      opsu_pkg::MS_DT: begin
        opa = {{17{d_iq[47]}}, d_iq};
        opb = {{27{t_jq[37]}}, t_jq};
      end
      opsu_pkg::MS_TM: begin
        opa = {{27{t_iq[37]}}, t_iq};
        opb = {m_r[k_qj][63], m_r[k_qj]};
      end
      opsu_pkg::MS_GE: begin
        opa = {{17{dg_r[k_iq][47]}}, dg_r[k_iq]};
        opb = {{33{e_r[cmd.q][31]}}, e_r[cmd.q]};
      end
      opsu_pkg::MS_EY: begin
        opa = {{33{e_r[cmd.q][31]}}, e_r[cmd.q]};
        opb = {ysat_r[cmd.q][63], ysat_r[cmd.q]};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    opa_abs = opa[64] ? (~opa + 65'd1) : opa;
    opb_abs = opb[64] ? (~opb + 65'd1) : opb;
  end

  opsu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_neg (opa[64]),
    .a_mag (opa_abs[63:0]),
    .b_neg (opb[64]),
    .b_mag (opb_abs[63:0]),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  opsu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (k_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Saturation and row arithmetic
  always_comb begin
    cfg_bad = (e1_r == '0) || (e2_r == '0) || (g12_r == '0) ||
              (mul_prod[63:0] >= {4'b0, e1_r, 28'b0});
    quo_x   = div_quo;
    m_sat   = opsu_pkg::sat_s64(acc_r >>> opsu_pkg::FRAC_SHIFT);
    y_row   = acc_r >>> opsu_pkg::Y_SHIFT;
    row_sum = {{64{stress_r[cmd.i][63]}}, stress_r[cmd.i]} + y_row;
    row_sat = opsu_pkg::sat_s64(row_sum);
    y_sat   = opsu_pkg::sat_s64(y_row);
    en_sat  = opsu_pkg::sat_s64(acc_r >>> opsu_pkg::E_SHIFT);
  end

  // Item control state: stress store and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stress_r[0] <= '0;
      stress_r[1] <= '0;
      stress_r[2] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result takes precedence over clearing the one just transferred
      if (cmd.act == opsu_pkg::ACT_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.act == opsu_pkg::ACT_ROW && !op_r) begin
        stress_r[cmd.i] <= row_sat.val;
      end
    end
  end

  // Payload registers driven by the controller's actions
  always_ff @(posedge clk) begin
    case (cmd.act)
      opsu_pkg::ACT_LATCH_IN: begin
        op_r     <= in_opcode;
        e_r[0]   <= in_strain_x;
        e_r[1]   <= in_strain_y;
        e_r[2]   <= in_strain_shear;
        clip_r   <= 1'b0;
        energy_r <= '0;
        bad_r    <= 1'b0;
      end
      opsu_pkg::ACT_CHECK: begin
        bad_r <= cfg_bad;
        k_r   <= {4'b0, e1_r, 28'b0} - mul_prod[63:0];
      end
      opsu_pkg::ACT_LOAD_NUM: begin
        if (cmd.dsel == opsu_pkg::DS_D01) begin
          num_r <= mul_prod << opsu_pkg::NU_SHIFT;
        end else begin
          num_r <= mul_prod << opsu_pkg::MOD_SHIFT;
        end
        if (cmd.dsel == opsu_pkg::DS_D11) begin
          ab_r <= mul_prod[63:0];
        end
      end
      opsu_pkg::ACT_STORE_D: begin
        case (cmd.dsel)
          opsu_pkg::DS_D00: d00_r <= {1'b0, quo_x};
          opsu_pkg::DS_D11: d11_r <= {1'b0, quo_x};
          opsu_pkg::DS_D01: d01_r <= nu_r[15] ? -{1'b0, quo_x} : {1'b0, quo_x};
          default: ;
        endcase
      end
      opsu_pkg::ACT_CLR_ACC: acc_r <= '0;
      opsu_pkg::ACT_ACC:     acc_r <= acc_r + mul_prod;
      opsu_pkg::ACT_STORE_M: m_r[k_ij] <= m_sat.val;
      opsu_pkg::ACT_STORE_G: dg_r[k_ij] <= opsu_pkg::sat_s48(acc_r >>> opsu_pkg::FRAC_SHIFT);
      opsu_pkg::ACT_ROW: begin
        if (op_r) begin
          ysat_r[cmd.i] <= y_sat.val;
          if (y_sat.clip) begin
            clip_r <= 1'b1;
          end
        end else if (row_sat.clip) begin
          clip_r <= 1'b1;
        end
      end
      opsu_pkg::ACT_ENERGY: begin
        energy_r <= en_sat.val;
        if (en_sat.clip) begin
          clip_r <= 1'b1;
        end
      end
      opsu_pkg::ACT_OUT: begin
        out_sx_r  <= stress_r[0];
        out_sy_r  <= stress_r[1];
        out_ss_r  <= stress_r[2];
        out_en_r  <= energy_r;
        out_sat_r <= clip_r;
        out_bad_r <= bad_r;
      end
      default: ;
    endcase
  end

  // Status to the controller
  always_comb begin
    stat.mul_busy = mul_busy;
    stat.mul_done = mul_done;
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.bad      = bad_r;
    stat.opcode   = op_r;
    stat.out_full = out_valid_r && !out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_stress_x     = out_sx_r;
  assign out_stress_y     = out_sy_r;
  assign out_stress_shear = out_ss_r;
  assign out_energy       = out_en_r;
  assign out_saturated    = out_sat_r;
  assign out_config_error = out_bad_r;

endmodule

>>> rtl/core/opsu_ctrl.sv
// Controller: sequences the check, stiffness build and per-item multiply-accumulates.
`include "orthotropic_plane_stress_update_assert.svh"

module opsu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_wr,
  input  opsu_pkg::opsu_stat_t stat,
  output opsu_pkg::opsu_cmd_t  cmd
);

  opsu_pkg::state_t state_r, state_nxt;
  opsu_pkg::phase_t phase_r, phase_nxt;
  opsu_pkg::dsel_t  dsel_r, dsel_nxt;
  logic [1:0]       i_r, i_nxt;
  logic [1:0]       j_r, j_nxt;
  logic [1:0]       q_r, q_nxt;
  logic             valid_r, valid_nxt;
  logic             mul_wait;

  // Next state and loop counters
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    dsel_nxt  = dsel_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    q_nxt     = q_r;
    valid_nxt = valid_r;
    case (state_r)
      opsu_pkg::S_IDLE: begin
        if (in_valid) begin
          i_nxt = '0;
          j_nxt = '0;
          // A register write in the same cycle makes the cache stale for this item too
          if (valid_r && !cfg_wr) begin
            phase_nxt = opsu_pkg::PH_Y;
            state_nxt = opsu_pkg::S_MAC_CLR;
          end else begin
            state_nxt = opsu_pkg::S_CHK_MUL;
          end
        end
      end
      opsu_pkg::S_CHK_MUL: state_nxt = opsu_pkg::S_CHK_WAIT;
      opsu_pkg::S_CHK_WAIT: begin
        if (stat.mul_done) begin
          state_nxt = opsu_pkg::S_CHK_DEC;
        end
      end
      opsu_pkg::S_CHK_DEC: begin
        if (stat.bad) begin
          state_nxt = opsu_pkg::S_OUT;
        end else begin
          dsel_nxt  = opsu_pkg::DS_D00;
          state_nxt = opsu_pkg::S_D_MUL;
        end
      end
      opsu_pkg::S_D_MUL: state_nxt = opsu_pkg::S_D_WAIT;
      opsu_pkg::S_D_WAIT: begin
        if (stat.mul_done) begin
          state_nxt = opsu_pkg::S_D_DIV;
        end
      end
      opsu_pkg::S_D_DIV: state_nxt = opsu_pkg::S_D_DWAIT;
      opsu_pkg::S_D_DWAIT: begin
        if (stat.div_done) begin
          case (dsel_r)
            opsu_pkg::DS_D00: begin
              dsel_nxt  = opsu_pkg::DS_D11;
              state_nxt = opsu_pkg::S_D_MUL;
            end
            opsu_pkg::DS_D11: begin
              dsel_nxt  = opsu_pkg::DS_D01;
              state_nxt = opsu_pkg::S_D_MUL;
            end
            default: begin
              phase_nxt = opsu_pkg::PH_M;
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = opsu_pkg::S_MAC_CLR;
            end
          endcase
        end
      end
      opsu_pkg::S_MAC_CLR: begin
        q_nxt     = '0;
        state_nxt = opsu_pkg::S_MAC_MUL;
      end
      opsu_pkg::S_MAC_MUL: state_nxt = opsu_pkg::S_MAC_WAIT;
      opsu_pkg::S_MAC_WAIT: begin
        if (stat.mul_done) begin
          if (q_r == 2'd2) begin
            state_nxt = opsu_pkg::S_MAC_END;
          end else begin
            q_nxt     = q_r + 2'd1;
            state_nxt = opsu_pkg::S_MAC_MUL;
          end
        end
      end
      opsu_pkg::S_MAC_END: begin
        state_nxt = opsu_pkg::S_MAC_CLR;
        case (phase_r)
          opsu_pkg::PH_M, opsu_pkg::PH_G: begin
            if (j_r == 2'd2) begin
              j_nxt = '0;
              if (i_r == 2'd2) begin
                i_nxt = '0;
                if (phase_r == opsu_pkg::PH_M) begin
                  phase_nxt = opsu_pkg::PH_G;
                end else begin
                  phase_nxt = opsu_pkg::PH_Y;
                  valid_nxt = 1'b1;
                end
              end else begin
                i_nxt = i_r + 2'd1;
              end
            end else begin
              j_nxt = j_r + 2'd1;
            end
          end
          opsu_pkg::PH_Y: begin
            if (i_r == 2'd2) begin
              if (stat.opcode) begin
                phase_nxt = opsu_pkg::PH_E;
              end else begin
                state_nxt = opsu_pkg::S_OUT;
              end
            end else begin
              i_nxt = i_r + 2'd1;
            end
          end
          default: state_nxt = opsu_pkg::S_OUT;
        endcase
      end
      opsu_pkg::S_OUT: begin
        if (!stat.out_full) begin
          state_nxt = opsu_pkg::S_IDLE;
        end
      end
      default: state_nxt = opsu_pkg::S_IDLE;
    endcase
    // A register write makes the cached stiffness stale
    if (cfg_wr) begin
      valid_nxt = 1'b0;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = opsu_pkg::MS_NNE2;
    cmd.div_start = 1'b0;
    cmd.act       = opsu_pkg::ACT_NONE;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.q         = q_r;
    cmd.dsel      = dsel_r;
    in_ready      = 1'b0;
    case (state_r)
      opsu_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.act = opsu_pkg::ACT_LATCH_IN;
        end
      end
      opsu_pkg::S_CHK_MUL: cmd.mul_start = 1'b1;
      opsu_pkg::S_CHK_WAIT: begin
        if (stat.mul_done) begin
          cmd.act = opsu_pkg::ACT_CHECK;
        end
      end
      opsu_pkg::S_D_MUL: begin
        cmd.mul_start = 1'b1;
        case (dsel_r)
          opsu_pkg::DS_D00: cmd.mul_sel = opsu_pkg::MS_AA;
          opsu_pkg::DS_D11: cmd.mul_sel = opsu_pkg::MS_AB;
          default:          cmd.mul_sel = opsu_pkg::MS_ABN;
        endcase
      end
      opsu_pkg::S_D_WAIT: begin
        if (stat.mul_done) begin
          cmd.act = opsu_pkg::ACT_LOAD_NUM;
        end
      end
      opsu_pkg::S_D_DIV: cmd.div_start = 1'b1;
      opsu_pkg::S_D_DWAIT: begin
        if (stat.div_done) begin
          cmd.act = opsu_pkg::ACT_STORE_D;
        end
      end
      opsu_pkg::S_MAC_CLR: cmd.act = opsu_pkg::ACT_CLR_ACC;
      opsu_pkg::S_MAC_MUL: begin
        cmd.mul_start = 1'b1;
        case (phase_r)
          opsu_pkg::PH_M: cmd.mul_sel = opsu_pkg::MS_DT;
          opsu_pkg::PH_G: cmd.mul_sel = opsu_pkg::MS_TM;
          opsu_pkg::PH_Y: cmd.mul_sel = opsu_pkg::MS_GE;
          default:        cmd.mul_sel = opsu_pkg::MS_EY;
        endcase
      end
      opsu_pkg::S_MAC_WAIT: begin
        if (stat.mul_done) begin
          cmd.act = opsu_pkg::ACT_ACC;
        end
      end
      opsu_pkg::S_MAC_END: begin
        case (phase_r)
          opsu_pkg::PH_M: cmd.act = opsu_pkg::ACT_STORE_M;
          opsu_pkg::PH_G: cmd.act = opsu_pkg::ACT_STORE_G;
          opsu_pkg::PH_Y: cmd.act = opsu_pkg::ACT_ROW;
          default:        cmd.act = opsu_pkg::ACT_ENERGY;
        endcase
      end
      opsu_pkg::S_OUT: begin
        if (!stat.out_full) begin
          cmd.act = opsu_pkg::ACT_OUT;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= opsu_pkg::S_IDLE;
      phase_r <= opsu_pkg::PH_M;
      dsel_r  <= opsu_pkg::DS_D00;
      i_r     <= '0;
      j_r     <= '0;
      q_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      dsel_r  <= dsel_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      q_r     <= q_nxt;
      valid_r <= valid_nxt;
    end
  end

  // States in which the controller waits for a product
  assign mul_wait = (state_r == opsu_pkg::S_CHK_WAIT) || (state_r == opsu_pkg::S_D_WAIT) ||
                    (state_r == opsu_pkg::S_MAC_WAIT);

  // A product is only requested from an idle multiplier, which then runs
  `OPSU_ASSERT_IMPL(a_mul_start_idle, cmd.mul_start, !stat.mul_busy)
  `OPSU_ASSERT_NEXT(a_mul_start_runs, cmd.mul_start, stat.mul_busy)
  // Unit completions only arrive while the controller is waiting for them
  `OPSU_ASSERT_IMPL(a_mul_done_waited, stat.mul_done, mul_wait)
  `OPSU_ASSERT_IMPL(a_div_done_waited, stat.div_done, state_r == opsu_pkg::S_D_DWAIT)

endmodule

>>> rtl/core/orthotropic_plane_stress_update.sv
// After reset or a register write the first item also rebuilds the stiffness.
// With invalid registers the result follows the check alone, without a rebuild.
// The next transfer is taken while a result waits in the result register.
// The shared 32x32 multiplier and the bit-serial divider set the pace of each item.
// Synchronous active-low reset clears the stored stress, cache flag and handshake state.
module orthotropic_plane_stress_update (
  input  logic       clk,
  input  logic       rst_n,
  opsu_in_if.sink    in_ch,
  opsu_out_if.source out_ch,
  opsu_cfg_if.sink   cfg_ch
);

  opsu_pkg::opsu_cmd_t  cmd;
  opsu_pkg::opsu_stat_t stat;
  logic                 cfg_wr;

  // Configuration writes are always taken; indexes beyond the list are dropped
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_wr = cfg_ch.valid && (cfg_ch.index inside {[opsu_pkg::REG_MOD_ONE:opsu_pkg::REG_ROT_SIN]});
  end

  opsu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cfg_wr   (cfg_wr),
    .stat     (stat),
    .cmd      (cmd)
  );

  opsu_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr           (cfg_wr),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .in_opcode        (in_ch.opcode),
    .in_strain_x      (in_ch.strain_x),
    .in_strain_y      (in_ch.strain_y),
    .in_strain_shear  (in_ch.strain_shear),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_stress_x     (out_ch.stress_x),
    .out_stress_y     (out_ch.stress_y),
    .out_stress_shear (out_ch.stress_shear),
    .out_energy       (out_ch.energy),
    .out_saturated    (out_ch.saturated),
    .out_config_error (out_ch.config_error)
  );

endmodule

>>> tb/orthotropic_plane_stress_update_tb.sv
// Testbench for the orthotropic plane-stress block: a self-checking random and directed test.
`timescale 1ns / 1ps

module orthotropic_plane_stress_update_tb;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [63:0] stress_x;
    logic signed [63:0] stress_y;
    logic signed [63:0] stress_shear;
    logic signed [63:0] energy;
    logic               saturated;
    logic               config_error;
  } stress_result_t;

  // Material-point predictor and queue of expected stress results.
  class stress_scoreboard;
    logic [31:0] mod_one, mod_two, shear_mod;
    logic [15:0] nu_raw;
    logic [17:0] cos_raw, sin_raw;
    longint stress[3];
    longint rot_stiff[9];
    bit stiff_ready;
    stress_result_t awaited[$];
    int failures;
    int checked;
    int energy_seen;
    int error_seen;
    int clip_seen;

    function new();
      mod_one = 65536;
      mod_two = 65536;
      nu_raw = 0;
      shear_mod = 65536;
      cos_raw = 65536;
      sin_raw = 0;
      stress = '{0, 0, 0};
      stiff_ready = 0;
      failures = 0;
      checked = 0;
    endfunction

    function void write_reg(opsu_pkg::reg_idx_t idx, logic [31:0] v);
      case (idx)
        opsu_pkg::REG_MOD_ONE: mod_one = v;
        opsu_pkg::REG_MOD_TWO: mod_two = v;
        opsu_pkg::REG_POISSON: nu_raw = v[15:0];
        opsu_pkg::REG_SHEAR:   shear_mod = v;
        opsu_pkg::REG_ROT_COS: cos_raw = v[17:0];
        opsu_pkg::REG_ROT_SIN: sin_raw = v[17:0];
        default: ;
      endcase
      stiff_ready = 0;
    endfunction

    function bit config_invalid();
      longint n;
      longint unsigned nn;
      longint unsigned lhs;
      n = longint'($signed(nu_raw));
      nn = n * n;
      lhs = nn * {32'b0, mod_two};
      return mod_one == 0 || mod_two == 0 || shear_mod == 0 || lhs >= ({32'b0, mod_one} << 28);
    endfunction

    // Clip to the signed range of the given width.
    function longint clamp(logic signed [127:0] x, int w, inout bit clip);
      logic signed [127:0] hi;
      logic signed [127:0] lo;
      hi = (128'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
        clip = 1;
        return longint'(hi);
      end
      if (x < lo) begin
        clip = 1;
        return longint'(lo);
      end
      return longint'(x);
    endfunction

    function longint quot47(logic [127:0] num, logic [63:0] den);
      logic [127:0] q;
      q = num / {64'b0, den};
      if (q > 128'h7FFF_FFFF_FFFF) return 64'h7FFF_FFFF_FFFF;
      return longint'(q);
    endfunction

    // Local stiffness, then rotation into the global frame.
    function void build_stiffness();
      longint n, c, s, cc, ss, cs;
      longint unsigned nmag;
      logic [63:0] k, ab;
      longint d[9], t[9], mt[9];
      logic signed [127:0] acc, p, q;
      bit dummy;
      n = longint'($signed(nu_raw));
      nmag = n < 0 ? -n : n;
      k = ({32'b0, mod_one} << 28) - 64'(n * n) * {32'b0, mod_two};
      ab = {32'b0, mod_one} * {32'b0, mod_two};
      d = '{default: 0};
      d[0] = quot47(({96'b0, mod_one} * {96'b0, mod_one}) << 28, k);
      d[4] = quot47({64'b0, ab} << 28, k);
      d[1] = quot47(({64'b0, ab} * {64'b0, nmag}) << 14, k);
      if (n < 0) d[1] = -d[1];
      d[3] = d[1];
      d[8] = longint'({32'b0, shear_mod});
      c = longint'($signed(cos_raw));
      s = longint'($signed(sin_raw));
      cc = c * c;
      ss = s * s;
      cs = c * s;
      t = '{cc, ss, 2 * cs, ss, cc, -2 * cs, -cs, cs, cc - ss};
      dummy = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int m = 0; m < 3; m++) begin
            p = d[i * 3 + m];
            q = t[j * 3 + m];
            acc += p * q;
          end
          mt[i * 3 + j] = clamp(acc >>> 32, 64, dummy);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int m = 0; m < 3; m++) begin
            p = t[i * 3 + m];
            q = mt[m * 3 + j];
            acc += p * q;
          end
          rot_stiff[i * 3 + j] = clamp(acc >>> 32, 48, dummy);
        end
      end
    endfunction

    // Works out the result of one accepted strain transfer.
    function void note_input(logic op, logic signed [31:0] ex, logic signed [31:0] ey,
                             logic signed [31:0] eg);
      stress_result_t r;
      logic signed [127:0] strain[3];
      logic signed [127:0] y[3];
      logic signed [127:0] acc, p, yi;
      bit clip;
      strain[0] = ex;
      strain[1] = ey;
      strain[2] = eg;
      clip = 0;
      r.energy = 0;
      r.config_error = config_invalid();
      if (!r.config_error) begin
        if (!stiff_ready) begin
          build_stiffness();
          stiff_ready = 1;
        end
        for (int i = 0; i < 3; i++) begin
          acc = 0;
          for (int j = 0; j < 3; j++) begin
            p = rot_stiff[i * 3 + j];
            acc += p * strain[j];
          end
          y[i] = acc >>> (opsu_pkg::STRAIN_FRAC_BITS - 16);
        end
        if (op == 1'b0) begin
          for (int i = 0; i < 3; i++) begin
            p = stress[i];
            stress[i] = clamp(p + y[i], 64, clip);
          end
        end else begin
          acc = 0;
          for (int i = 0; i < 3; i++) begin
            yi = clamp(y[i], 64, clip);
            acc += strain[i] * yi;
          end
          r.energy = clamp(acc >>> (opsu_pkg::STRAIN_FRAC_BITS + 1), 64, clip);
        end
      end
      r.stress_x = stress[0];
      r.stress_y = stress[1];
      r.stress_shear = stress[2];
      r.saturated = clip;
      awaited.push_back(r);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check(stress_result_t got);
      stress_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result transfer with no expected result waiting");
        failures++;
        return;
      end
      exp_r = awaited.pop_front();
      checked++;
      if (exp_r.energy != 0) energy_seen++;
      if (exp_r.config_error) error_seen++;
      if (exp_r.saturated) clip_seen++;
      if (got.stress_x !== exp_r.stress_x) begin
        $error("stress_x: expected %0d, got %0d", exp_r.stress_x, got.stress_x);
        failures++;
      end
      if (got.stress_y !== exp_r.stress_y) begin
        $error("stress_y: expected %0d, got %0d", exp_r.stress_y, got.stress_y);
        failures++;
      end
      if (got.stress_shear !== exp_r.stress_shear) begin
        $error("stress_shear: expected %0d, got %0d", exp_r.stress_shear, got.stress_shear);
        failures++;
      end
      if (got.energy !== exp_r.energy) begin
        $error("energy: expected %0d, got %0d", exp_r.energy, got.energy);
        failures++;
      end
      if (got.saturated !== exp_r.saturated) begin
        $error("saturated: expected %0d, got %0d", exp_r.saturated, got.saturated);
        failures++;
      end
      if (got.config_error !== exp_r.config_error) begin
        $error("config_error: expected %0d, got %0d", exp_r.config_error, got.config_error);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   items_sent;

  opsu_in_if  in_ch();
  opsu_out_if out_ch();
  opsu_cfg_if cfg_ch();

  stress_scoreboard stress_sb;

  orthotropic_plane_stress_update DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Clock generation.
  always #1 clk = ~clk;

  // Cycle counter and run-time guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the next ready level.
  always @(posedge clk) begin
    stress_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.stress_x = out_ch.stress_x;
      got.stress_y = out_ch.stress_y;
      got.stress_shear = out_ch.stress_shear;
      got.energy = out_ch.energy;
      got.saturated = out_ch.saturated;
      got.config_error = out_ch.config_error;
      stress_sb.check(got);
    end
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // One strain transfer, with a random gap before it in the idling phases.
  task automatic send_strain(logic op, logic signed [31:0] ex, logic signed [31:0] ey,
                             logic signed [31:0] eg);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.strain_x <= ex;
    in_ch.strain_y <= ey;
    in_ch.strain_shear <= eg;
    do @(posedge clk); while (!in_ch.ready);
    stress_sb.note_input(op, ex, ey, eg);
    items_sent++;
  endtask

  // Holds the input off until every expected result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (stress_sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(opsu_pkg::reg_idx_t idx, logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    stress_sb.write_reg(idx, v);
  endtask

  // Writes all six registers once the block has gone idle.
  task automatic set_material(logic [31:0] e1, logic [31:0] e2, logic signed [15:0] nu,
                              logic [31:0] g12, logic signed [17:0] c, logic signed [17:0] s);
    drain();
    repeat (120) @(posedge clk);
    write_reg(opsu_pkg::REG_MOD_ONE, e1);
    write_reg(opsu_pkg::REG_MOD_TWO, e2);
    write_reg(opsu_pkg::REG_POISSON, 32'(nu));
    write_reg(opsu_pkg::REG_SHEAR, g12);
    write_reg(opsu_pkg::REG_ROT_COS, 32'(c));
    write_reg(opsu_pkg::REG_ROT_SIN, 32'(s));
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly moderate strains, sometimes the full 32-bit range.
  function automatic logic signed [31:0] pick_strain();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  initial begin
    logic [31:0] e1, e2, g12;
    logic signed [15:0] nu;
    clk = 0;
    rst_n = 0;
    cycles = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_ch.valid = 0;
    in_ch.opcode = 0;
    in_ch.strain_x = 0;
    in_ch.strain_y = 0;
    in_ch.strain_shear = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = opsu_pkg::REG_MOD_ONE;
    cfg_ch.data = 0;
    stress_sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: default material, zero and extreme strains, both operations.
    send_strain(1'b0, 0, 0, 0);
    send_strain(1'b1, 0, 0, 0);
    send_strain(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_strain(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_strain(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_strain(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_strain(1'b0, 32'sh4000_0000, -32'sh4000_0000, 1);
    // Stiffest valid material with a non-unit rotation drives the stress into saturation.
    set_material(32'hFFFF_FFFF, 32'd1, 16'sh7FFF, 32'hFFFF_FFFF, -18'sd65536, 18'sd65536);
    for (int i = 0; i < 4; i++) send_strain(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_strain(1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_strain(1'b1, -1, 1, -1);
    // Poisson ratio too large: the error flag is raised and the stress is held.
    set_material(32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd32768, 32'hFFFF_FFFF, 18'sd0, 18'sd0);
    send_strain(1'b0, 32'sh1000_0000, 5, -5);
    send_strain(1'b1, 32'sh1000_0000, 5, -5);
    // Smallest moduli, negative Poisson ratio, sine only.
    set_material(32'd1, 32'd1, -16'sd8000, 32'd1, 18'sd0, -18'sd65536);
    send_strain(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_strain(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_strain(1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);

    // Random part: a fresh material per phase, idling pattern rotating through phases.
    for (int ph = 0; ph < 12; ph++) begin
      e1 = $urandom_range(32'h0000_1000, 32'h0100_0000);
      e2 = $urandom_range(32'h0000_1000, 32'h0100_0000);
      g12 = $urandom_range(32'h0000_1000, 32'h0100_0000);
      nu = 16'($signed($urandom_range(0, 12000)) - 32'sd6000);
      if (ph == 3) e1 = $urandom;
      if (ph == 7) nu = 16'sh7FFF;
      set_material(e1, e2, nu, g12, 18'($signed($urandom_range(0, 131072)) - 32'sd65536),
                   18'($signed($urandom_range(0, 131072)) - 32'sd65536));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < 95; n++) begin
        if ($urandom_range(0, 59) == 0) drain();
        send_strain(1'($urandom_range(0, 1)), pick_strain(), pick_strain(), pick_strain());
      end
    end

    // Wait for the last results, then let the block settle.
    in_ch.valid <= 1'b0;
    while (stress_sb.awaited.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d strain transfers; checked %0d results (%0d with energy, %0d flagged",
             items_sent, stress_sb.checked, stress_sb.energy_seen, stress_sb.error_seen);
    $display("as config errors, %0d saturated) over %0d material settings.",
             stress_sb.clip_seen, 15);
    if (stress_sb.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/opsu_pkg.sv
rtl/core/opsu_if.sv
rtl/core/opsu_mul.sv
rtl/core/opsu_div.sv
rtl/core/opsu_datapath.sv
rtl/core/opsu_ctrl.sv
rtl/core/orthotropic_plane_stress_update.sv
tb/orthotropic_plane_stress_update_tb.sv
